[hw/rtl/ljbsa_pkg.sv]
// Shared types, constants and saturating helpers for the LJ Born/stress accumulator.
`timescale 1ns / 1ps
package ljbsa_pkg;

  localparam int WORD_W = 64;
  localparam int SH_W   = 7;

  localparam logic [WORD_W-1:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [WORD_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

  localparam logic [WORD_W-1:0] BORN_POS_K = 64'd672;
  localparam logic [WORD_W-1:0] BORN_NEG_K = 64'd192;
  localparam logic [WORD_W-1:0] VIR_POS_K  = 64'd24;
  localparam logic [WORD_W-1:0] VIR_NEG_K  = 64'd48;
  localparam logic [SH_W-1:0]   SH_Q32     = 7'd32;
  localparam logic [SH_W-1:0]   SH_NONE    = 7'd0;

  typedef enum logic [2:0] {
    REG_BOX, REG_CUT, REG_P, REG_Q, REG_R, REG_S, REG_INV_VOL, REG_RHO_T
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    STEP_SQ_X, STEP_SQ_Y, STEP_SQ_Z, STEP_I4, STEP_I8, STEP_I10, STEP_I12, STEP_I14,
    STEP_I16, STEP_MPQ, STEP_MRS, STEP_M4, STEP_BORN_POS, STEP_BORN_NEG, STEP_VIR_POS,
    STEP_VIR_NEG, STEP_BORN_A, STEP_BORN_B, STEP_IJ_A, STEP_IJ_B, STEP_KL_A, STEP_KL_B,
    STEP_NORM_IJ, STEP_NORM_KL, STEP_PROD
  } step_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [SH_W-1:0]   sh;
  } mul_req_t;

  function automatic logic [WORD_W-1:0] to_signed(logic [WORD_W-1:0] mag, logic neg);
    logic [WORD_W-1:0] r;
    if (neg) r = mag[WORD_W-1] ? S64_MIN : (~mag + 64'd1);
    else     r = mag[WORD_W-1] ? S64_MAX : mag;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_sub(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mag64(logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 64'd1) : v;
  endfunction

endpackage

[hw/rtl/ljbsa_mul.sv]
// Shared 64x64 multiplier: four 32x32 partial products, then saturating right shift.
`timescale 1ns / 1ps
module ljbsa_mul import ljbsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mul_req_t          req,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  logic [WORD_W-1:0]   a_r, b_r;
  logic [SH_W-1:0]     sh_r;
  logic [2*WORD_W-1:0] acc_r;
  logic [1:0]          cnt_r;
  logic                busy_r, done_r;
  logic [31:0]         a_half, b_half;
  logic [WORD_W-1:0]   pp;
  logic [1:0]          off;
  logic [2*WORD_W-1:0] pp_ext, shifted;

  assign a_half  = cnt_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_half  = cnt_r[1] ? b_r[63:32] : b_r[31:0];
  assign pp      = {32'd0, a_half} * {32'd0, b_half};
  assign off     = {cnt_r[0] & cnt_r[1], cnt_r[0] ^ cnt_r[1]};
  assign pp_ext  = {64'd0, pp} << {off, 5'd0};
  assign shifted = acc_r >> sh_r;
  assign result  = (|shifted[2*WORD_W-1:WORD_W]) ? {WORD_W{1'b1}} : shifted[WORD_W-1:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      sh_r  <= req.sh;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_ext;
    end
  end

endmodule

[hw/rtl/ljbsa_div.sv]
// Restoring divider: all-ones 64-bit dividend over a 64-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module ljbsa_div import ljbsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic [WORD_W-1:0] d_r, rem_r, q_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [WORD_W:0]   trial, diff;

  assign trial    = {rem_r, 1'b1};
  assign diff     = trial - {1'b0, d_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        q_r   <= {q_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[WORD_W-1:0];
        q_r   <= {q_r[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/lj_pair_born_stress_accumulator_core.sv]
// Top level: sequencer and accumulators of the LJ Born term and virial stress block.
//
//  channel | signals                                  | role
//  in      | in_valid/in_ready, op, diff_x/y/z        | pair or frame-end word
//  out     | out_valid/out_ready, 8 result fields     | one result word per input
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata          | register write, no wait
//
// A pair inside the cutoff goes through accept, three squares on the shared
// multiplier, the cutoff check, the bit-serial divider, the remaining products
// and the result hand-off: 22 products in all. A pair outside the cutoff skips
// the divider and later products; a frame end runs three products.
// in_ready only while idle. A finished word moves to the output register and the
// next word starts; a further finished word waits until that one is taken.
// Synchronous active-low reset clears control state, accumulators and output word.
`timescale 1ns / 1ps
module lj_pair_born_stress_accumulator_core import ljbsa_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int ACC_FRAC_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [24:0] in_diff_x,
  input  logic [24:0] in_diff_y,
  input  logic [24:0] in_diff_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_within_cutoff,
  output logic [63:0] out_born_total,
  output logic [63:0] out_frame_sigma_ij,
  output logic [63:0] out_frame_sigma_kl,
  output logic [63:0] out_product_total,
  output logic [63:0] out_sigma_ij_total,
  output logic [63:0] out_sigma_kl_total,
  output logic [31:0] out_frames_done,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int FSH    = 2 * COORD_FRAC_BITS - 32;
  localparam int FSH_R  = (FSH > 0) ? FSH : 0;
  localparam int FSH_L  = (FSH < 0) ? -FSH : 0;
  localparam int CUT_SH = 2 * COORD_FRAC_BITS - 16;
  localparam int KIN_SH = 32 - ACC_FRAC_BITS;
  localparam logic [SH_W-1:0] SH_M4  = SH_W'(2 * COORD_FRAC_BITS);
  localparam logic [SH_W-1:0] SH_T   = SH_W'(32 + 2 * COORD_FRAC_BITS - ACC_FRAC_BITS);
  localparam logic [SH_W-1:0] SH_ACC = SH_W'(ACC_FRAC_BITS);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   hit_r, hit_nxt;

  logic [23:0] box_r;
  logic [31:0] cut_r, inv_vol_r, rho_t_r;
  logic [1:0]  idx_p_r, idx_q_r, idx_r_r, idx_s_r;

  logic [24:0] mag_x_r, mag_y_r, mag_z_r, mag_x_nxt, mag_y_nxt, mag_z_nxt;
  logic        neg_x_r, neg_y_r, neg_z_r, neg_x_nxt, neg_y_nxt, neg_z_nxt;

  logic [63:0] r2_r, i2_r, i4_r, i8_r, i10_r, i14_r, i16_r, mpq_r, mrs_r, m4_r, ta_r;
  logic [63:0] sij_r, skl_r;
  logic [63:0] r2_nxt, i2_nxt, i4_nxt, i8_nxt, i10_nxt, i14_nxt, i16_nxt, mpq_nxt;
  logic [63:0] mrs_nxt, m4_nxt, ta_nxt, sij_nxt, skl_nxt;
  logic [63:0] born_r, fij_r, fkl_r, prod_r, tij_r, tkl_r;
  logic [63:0] born_nxt, fij_nxt, fkl_nxt, prod_nxt, tij_nxt, tkl_nxt;
  logic [31:0] frames_r, frames_nxt;

  logic        ov_r, o_hit_r;
  logic [63:0] o_born_r, o_fij_r, o_fkl_r, o_prod_r, o_tij_r, o_tkl_r;
  logic [31:0] o_frames_r;
  logic        load_out;

  mul_req_t    mreq;
  logic        mul_done, div_start, div_done;
  logic [63:0] mul_res, div_q, r32, kin, norm;
  logic [24:0] mag_p, mag_q, mag_r, mag_s;
  logic        neg_p, neg_q, neg_r, neg_s, n_pq, n_rs, n_b;
  logic [25:0] wx, wy, wz;

  function automatic logic [25:0] wrap_axis(logic [24:0] d, logic [23:0] box);
    logic [24:0] m;
    logic [25:0] w, wm;
    m = d[24] ? (~d + 25'd1) : d;
    w = {d[24], d};
    if ({m, 1'b0} > {2'b00, box}) w = d[24] ? w + {2'b00, box} : w - {2'b00, box};
    wm = w[25] ? (~w + 26'd1) : w;
    return {w[25], wm[24:0]};
  endfunction

  function automatic logic [25:0] pick(logic [1:0] idx, logic [25:0] x, logic [25:0] y,
                                       logic [25:0] z);
    logic [25:0] v;
    case (idx)
      2'd1:    v = x;
      2'd2:    v = y;
      2'd3:    v = z;
      default: v = '0;
    endcase
    return v;
  endfunction

  ljbsa_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mul_done), .result(mul_res));

  ljbsa_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .divisor(r32),
                   .done(div_done), .quotient(div_q));

  assign wx = wrap_axis(in_diff_x, box_r);
  assign wy = wrap_axis(in_diff_y, box_r);
  assign wz = wrap_axis(in_diff_z, box_r);

  assign {neg_p, mag_p} = pick(idx_p_r, {neg_x_r, mag_x_r}, {neg_y_r, mag_y_r},
                               {neg_z_r, mag_z_r});
  assign {neg_q, mag_q} = pick(idx_q_r, {neg_x_r, mag_x_r}, {neg_y_r, mag_y_r},
                               {neg_z_r, mag_z_r});
  assign {neg_r, mag_r} = pick(idx_r_r, {neg_x_r, mag_x_r}, {neg_y_r, mag_y_r},
                               {neg_z_r, mag_z_r});
  assign {neg_s, mag_s} = pick(idx_s_r, {neg_x_r, mag_x_r}, {neg_y_r, mag_y_r},
                               {neg_z_r, mag_z_r});
  assign n_pq = neg_p ^ neg_q;
  assign n_rs = neg_r ^ neg_s;
  assign n_b  = n_pq ^ n_rs;

  always_comb begin
    r32 = (r2_r >> FSH_R) << FSH_L;
    if (r32 == 64'd0) r32 = 64'd1;
  end

  assign kin = {32'd0, rho_t_r >> KIN_SH};

  // operand select for the shared multiplier
  always_comb begin
    mreq.start = (state_r == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.sh    = SH_NONE;
    case (step_r)
      STEP_SQ_X:     begin mreq.a = {39'd0, mag_x_r}; mreq.b = {39'd0, mag_x_r}; end
      STEP_SQ_Y:     begin mreq.a = {39'd0, mag_y_r}; mreq.b = {39'd0, mag_y_r}; end
      STEP_SQ_Z:     begin mreq.a = {39'd0, mag_z_r}; mreq.b = {39'd0, mag_z_r}; end
      STEP_I4:       begin mreq.a = i2_r;  mreq.b = i2_r;  mreq.sh = SH_Q32; end
      STEP_I8:       begin mreq.a = i4_r;  mreq.b = i4_r;  mreq.sh = SH_Q32; end
      STEP_I10:      begin mreq.a = i8_r;  mreq.b = i2_r;  mreq.sh = SH_Q32; end
      STEP_I12:      begin mreq.a = i8_r;  mreq.b = i4_r;  mreq.sh = SH_Q32; end
      STEP_I14:      begin mreq.a = i14_r; mreq.b = i2_r;  mreq.sh = SH_Q32; end
      STEP_I16:      begin mreq.a = i8_r;  mreq.b = i8_r;  mreq.sh = SH_Q32; end
      STEP_MPQ:      begin mreq.a = {39'd0, mag_p}; mreq.b = {39'd0, mag_q}; end
      STEP_MRS:      begin mreq.a = {39'd0, mag_r}; mreq.b = {39'd0, mag_s}; end
      STEP_M4:       begin mreq.a = mpq_r; mreq.b = mrs_r; mreq.sh = SH_M4; end
      STEP_BORN_POS: begin mreq.a = i16_r; mreq.b = BORN_POS_K; end
      STEP_BORN_NEG: begin mreq.a = i10_r; mreq.b = BORN_NEG_K; end
      STEP_VIR_POS:  begin mreq.a = i8_r;  mreq.b = VIR_POS_K; end
      STEP_VIR_NEG:  begin mreq.a = i14_r; mreq.b = VIR_NEG_K; end
      STEP_BORN_A:   begin mreq.a = i16_r; mreq.b = m4_r;  mreq.sh = SH_T; end
      STEP_BORN_B:   begin mreq.a = i10_r; mreq.b = m4_r;  mreq.sh = SH_T; end
      STEP_IJ_A:     begin mreq.a = i8_r;  mreq.b = mpq_r; mreq.sh = SH_T; end
      STEP_IJ_B:     begin mreq.a = i14_r; mreq.b = mpq_r; mreq.sh = SH_T; end
      STEP_KL_A:     begin mreq.a = i8_r;  mreq.b = mrs_r; mreq.sh = SH_T; end
      STEP_KL_B:     begin mreq.a = i14_r; mreq.b = mrs_r; mreq.sh = SH_T; end
      STEP_NORM_IJ:  begin mreq.a = mag64(fij_r); mreq.b = {32'd0, inv_vol_r};
                           mreq.sh = SH_Q32; end
      STEP_NORM_KL:  begin mreq.a = mag64(fkl_r); mreq.b = {32'd0, inv_vol_r};
                           mreq.sh = SH_Q32; end
      STEP_PROD:     begin mreq.a = mag64(sij_r); mreq.b = mag64(skl_r); mreq.sh = SH_ACC; end
      default:       ;
    endcase
  end

  assign div_start = (state_r == ST_DIV_GO);
  assign load_out  = (state_r == ST_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt  = state_r;  step_nxt  = step_r;   hit_nxt  = hit_r;
    mag_x_nxt  = mag_x_r;  mag_y_nxt = mag_y_r;  mag_z_nxt = mag_z_r;
    neg_x_nxt  = neg_x_r;  neg_y_nxt = neg_y_r;  neg_z_nxt = neg_z_r;
    r2_nxt = r2_r; i2_nxt = i2_r; i4_nxt = i4_r; i8_nxt = i8_r; i10_nxt = i10_r;
    i14_nxt = i14_r; i16_nxt = i16_r; mpq_nxt = mpq_r; mrs_nxt = mrs_r; m4_nxt = m4_r;
    ta_nxt = ta_r; sij_nxt = sij_r; skl_nxt = skl_r;
    born_nxt = born_r; fij_nxt = fij_r; fkl_nxt = fkl_r; prod_nxt = prod_r;
    tij_nxt = tij_r; tkl_nxt = tkl_r; frames_nxt = frames_r;
    norm = to_signed(mul_res, 1'b0);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_ISSUE;
          if (in_op) begin
            step_nxt = STEP_NORM_IJ;
          end else begin
            step_nxt = STEP_SQ_X;
            {neg_x_nxt, mag_x_nxt} = wx;
            {neg_y_nxt, mag_y_nxt} = wy;
            {neg_z_nxt, mag_z_nxt} = wz;
          end
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_ISSUE;
          step_nxt  = step_t'(step_r + 5'd1);
          case (step_r)
            STEP_SQ_X:     r2_nxt = mul_res;
            STEP_SQ_Y:     r2_nxt = r2_r + mul_res;
            STEP_SQ_Z: begin
              r2_nxt    = r2_r + mul_res;
              state_nxt = ST_CHECK;
            end
            STEP_I4:       i4_nxt  = mul_res;
            STEP_I8:       i8_nxt  = mul_res;
            STEP_I10:      i10_nxt = mul_res;
            STEP_I12:      i14_nxt = mul_res;
            STEP_I14:      i14_nxt = mul_res;
            STEP_I16:      i16_nxt = mul_res;
            STEP_MPQ:      mpq_nxt = mul_res;
            STEP_MRS:      mrs_nxt = mul_res;
            STEP_M4:       m4_nxt  = mul_res;
            STEP_BORN_POS: i16_nxt = mul_res;
            STEP_BORN_NEG: i10_nxt = mul_res;
            STEP_VIR_POS:  i8_nxt  = mul_res;
            STEP_VIR_NEG:  i14_nxt = mul_res;
            STEP_BORN_A, STEP_IJ_A, STEP_KL_A: ta_nxt = mul_res;
            STEP_BORN_B:
              born_nxt = sat_add(born_r, sat_sub(to_signed(ta_r, n_b), to_signed(mul_res, n_b)));
            STEP_IJ_B:
              fij_nxt = sat_add(fij_r, sat_sub(to_signed(ta_r, n_pq), to_signed(mul_res, n_pq)));
            STEP_KL_B: begin
              fkl_nxt = sat_add(fkl_r, sat_sub(to_signed(ta_r, n_rs), to_signed(mul_res, n_rs)));
              hit_nxt   = 1'b1;
              state_nxt = ST_OUT;
            end
            STEP_NORM_IJ: begin
              norm    = to_signed(mul_res, fij_r[63]);
              sij_nxt = (idx_p_r == idx_q_r) ? sat_sub(norm, kin) : norm;
            end
            STEP_NORM_KL: begin
              norm    = to_signed(mul_res, fkl_r[63]);
              skl_nxt = (idx_r_r == idx_s_r) ? sat_sub(norm, kin) : norm;
            end
            STEP_PROD: begin
              prod_nxt = sat_add(prod_r, to_signed(mul_res, sij_r[63] ^ skl_r[63]));
              tij_nxt  = sat_add(tij_r, sij_r);
              tkl_nxt  = sat_add(tkl_r, skl_r);
              fij_nxt  = '0;
              fkl_nxt  = '0;
              if (frames_r != 32'hffff_ffff) frames_nxt = frames_r + 32'd1;
              state_nxt = ST_OUT;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_CHECK: begin
        if (r2_r != 64'd0 && (r2_r >> CUT_SH) < {32'd0, cut_r}) state_nxt = ST_DIV_GO;
        else state_nxt = ST_OUT;
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          i2_nxt    = div_q;
          step_nxt  = STEP_I4;
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= STEP_SQ_X;
      hit_r     <= 1'b0;
      box_r     <= 24'd655360;
      cut_r     <= 32'd409600;
      idx_p_r   <= 2'd1;
      idx_q_r   <= 2'd1;
      idx_r_r   <= 2'd1;
      idx_s_r   <= 2'd1;
      inv_vol_r <= 32'd4294967;
      rho_t_r   <= 32'd4359392;
      born_r    <= '0;
      fij_r     <= '0;
      fkl_r     <= '0;
      prod_r    <= '0;
      tij_r     <= '0;
      tkl_r     <= '0;
      frames_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      hit_r    <= hit_nxt;
      born_r   <= born_nxt;
      fij_r    <= fij_nxt;
      fkl_r    <= fkl_nxt;
      prod_r   <= prod_nxt;
      tij_r    <= tij_nxt;
      tkl_r    <= tkl_nxt;
      frames_r <= frames_nxt;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_BOX:     box_r     <= cfg_wdata[23:0];
          REG_CUT:     cut_r     <= cfg_wdata;
          REG_P:       idx_p_r   <= cfg_wdata[1:0];
          REG_Q:       idx_q_r   <= cfg_wdata[1:0];
          REG_R:       idx_r_r   <= cfg_wdata[1:0];
          REG_S:       idx_s_r   <= cfg_wdata[1:0];
          REG_INV_VOL: inv_vol_r <= cfg_wdata;
          REG_RHO_T:   rho_t_r   <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_x_r <= mag_x_nxt; mag_y_r <= mag_y_nxt; mag_z_r <= mag_z_nxt;
    neg_x_r <= neg_x_nxt; neg_y_r <= neg_y_nxt; neg_z_r <= neg_z_nxt;
    r2_r <= r2_nxt; i2_r <= i2_nxt; i4_r <= i4_nxt; i8_r <= i8_nxt; i10_r <= i10_nxt;
    i14_r <= i14_nxt; i16_r <= i16_nxt; mpq_r <= mpq_nxt; mrs_r <= mrs_nxt; m4_r <= m4_nxt;
    ta_r <= ta_nxt; sij_r <= sij_nxt; skl_r <= skl_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r       <= 1'b0;
      o_hit_r    <= 1'b0;
      o_born_r   <= '0;
      o_fij_r    <= '0;
      o_fkl_r    <= '0;
      o_prod_r   <= '0;
      o_tij_r    <= '0;
      o_tkl_r    <= '0;
      o_frames_r <= '0;
    end else if (load_out) begin
      ov_r       <= 1'b1;
      o_hit_r    <= hit_r;
      o_born_r   <= born_r;
      o_fij_r    <= fij_r;
      o_fkl_r    <= fkl_r;
      o_prod_r   <= prod_r;
      o_tij_r    <= tij_r;
      o_tkl_r    <= tkl_r;
      o_frames_r <= frames_r;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = ov_r;
  assign out_within_cutoff  = o_hit_r;
  assign out_born_total     = o_born_r;
  assign out_frame_sigma_ij = o_fij_r;
  assign out_frame_sigma_kl = o_fkl_r;
  assign out_product_total  = o_prod_r;
  assign out_sigma_ij_total = o_tij_r;
  assign out_sigma_kl_total = o_tkl_r;
  assign out_frames_done    = o_frames_r;

  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid && !out_ready) |=> (state_r == ST_OUT))
    else $error("finished word overran pending output");

  a_frames_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r >= $past(frames_r)) else $error("frame count went back");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_frames_done) &&
      $stable(out_born_total))
    else $error("result changed while pending");

  a_frame_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_within_cutoff) |-> (out_frames_done == $past(out_frames_done)))
    else $error("pair result moved frame count");

endmodule

[bench/tb.sv]
// Self-checking bench for the LJ Born term and virial stress accumulator core.
`timescale 1ns / 1ps
module tb;
  import ljbsa_pkg::*;

  localparam logic OP_PAIR  = 1'b0;
  localparam logic OP_FRAME = 1'b1;
  localparam int   LIMIT    = 2000000;
  localparam int   DRAIN    = 300;

  typedef struct {
    logic        hit;
    logic [63:0] born, fij, fkl, prod, tij, tkl;
    logic [31:0] frames;
  } lj_word_t;

  typedef struct {
    logic        op;
    logic [24:0] dx, dy, dz;
    logic        typed;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready, in_op = 0;
  logic [24:0] in_diff_x = 0, in_diff_y = 0, in_diff_z = 0;
  logic out_valid, out_ready = 0, out_within_cutoff;
  logic [63:0] out_born_total, out_frame_sigma_ij, out_frame_sigma_kl;
  logic [63:0] out_product_total, out_sigma_ij_total, out_sigma_kl_total;
  logic [31:0] out_frames_done;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  lj_pair_born_stress_accumulator_core u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] box_q, cut_q, inv_vol_q, rho_t_q;
  logic [1:0]  ax_p, ax_q, ax_r, ax_s;
  logic [63:0] born_q, fij_q, fkl_q, prod_q, tij_q, tkl_q;
  logic [31:0] frames_q;

  lj_word_t lj_expected[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_req = 0;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] signed_of(logic [63:0] m, logic neg);
    if (neg) return m[63] ? 64'h8000_0000_0000_0000 : (64'd0 - m);
    return m[63] ? 64'h7fff_ffff_ffff_ffff : m;
  endfunction

  function automatic logic [63:0] clamp65(logic [64:0] s);
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    return s[63:0];
  endfunction

  function automatic logic [63:0] acc_add(logic [63:0] a, logic [63:0] b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic [63:0] acc_sub(logic [63:0] a, logic [63:0] b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic longint min_image(logic [24:0] raw);
    longint d, m;
    d = longint'($signed(raw));
    m = d < 0 ? -d : d;
    if (2 * m > longint'(box_q)) d = d < 0 ? d + longint'(box_q) : d - longint'(box_q);
    return d;
  endfunction

  function automatic logic [63:0] lj_term(logic [63:0] pc, logic [63:0] nc, logic [63:0] m,
                                          logic neg);
    return acc_sub(signed_of(mul_shr(pc, m, 40), neg), signed_of(mul_shr(nc, m, 40), neg));
  endfunction

  function automatic logic [63:0] stress_norm(logic [63:0] f, logic kin);
    logic [63:0] s;
    s = signed_of(mul_shr(magnitude(f), inv_vol_q, 32), f[63]);
    if (kin) s = acc_sub(s, rho_t_q >> 8);
    return s;
  endfunction

  task automatic lj_predict(input logic op, input logic [24:0] x, y, z, output lj_word_t w);
    longint c[4];
    logic [63:0] r2, i2, i4, i8, i10, i14, i16, mpq, mrs, m4, sij, skl;
    logic npq, nrs;
    w.hit = 0;
    if (op == OP_PAIR) begin
      c[0] = 0;
      c[1] = min_image(x);
      c[2] = min_image(y);
      c[3] = min_image(z);
      r2 = c[1] * c[1] + c[2] * c[2] + c[3] * c[3];
      if (r2 != 0 && (r2 >> 16) < cut_q) begin
        i2  = 64'hffff_ffff_ffff_ffff / r2;
        i4  = mul_shr(i2, i2, 32);
        i8  = mul_shr(i4, i4, 32);
        i10 = mul_shr(i8, i2, 32);
        i14 = mul_shr(mul_shr(i8, i4, 32), i2, 32);
        i16 = mul_shr(i8, i8, 32);
        mpq = 64'((c[ax_p] < 0 ? -c[ax_p] : c[ax_p]) * (c[ax_q] < 0 ? -c[ax_q] : c[ax_q]));
        mrs = 64'((c[ax_r] < 0 ? -c[ax_r] : c[ax_r]) * (c[ax_s] < 0 ? -c[ax_s] : c[ax_s]));
        npq = (c[ax_p] < 0) != (c[ax_q] < 0);
        nrs = (c[ax_r] < 0) != (c[ax_s] < 0);
        m4  = mul_shr(mpq, mrs, 32);
        born_q = acc_add(born_q, lj_term(mul_shr(i16, BORN_POS_K, 0),
                                         mul_shr(i10, BORN_NEG_K, 0), m4, npq != nrs));
        fij_q = acc_add(fij_q, lj_term(mul_shr(i8, VIR_POS_K, 0),
                                       mul_shr(i14, VIR_NEG_K, 0), mpq, npq));
        fkl_q = acc_add(fkl_q, lj_term(mul_shr(i8, VIR_POS_K, 0),
                                       mul_shr(i14, VIR_NEG_K, 0), mrs, nrs));
        w.hit = 1;
      end
    end else begin
      sij = stress_norm(fij_q, ax_p == ax_q);
      skl = stress_norm(fkl_q, ax_r == ax_s);
      prod_q = acc_add(prod_q, signed_of(mul_shr(magnitude(sij), magnitude(skl), 24),
                                         sij[63] != skl[63]));
      tij_q = acc_add(tij_q, sij);
      tkl_q = acc_add(tkl_q, skl);
      fij_q = 0;
      fkl_q = 0;
      if (frames_q != '1) frames_q++;
    end
    w.born = born_q; w.fij = fij_q; w.fkl = fkl_q;
    w.prod = prod_q; w.tij = tij_q; w.tkl = tkl_q; w.frames = frames_q;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %h exp %h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    lj_word_t e;
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (lj_expected.size() == 0) begin
        report("unexpected word", 64'(out_within_cutoff), 64'd0);
      end else begin
        e = lj_expected.pop_front();
        if (out_within_cutoff !== e.hit) report("within_cutoff", 64'(out_within_cutoff), 64'(e.hit));
        if (out_born_total !== e.born) report("born_total", out_born_total, e.born);
        if (out_frame_sigma_ij !== e.fij) report("frame_sigma_ij", out_frame_sigma_ij, e.fij);
        if (out_frame_sigma_kl !== e.fkl) report("frame_sigma_kl", out_frame_sigma_kl, e.fkl);
        if (out_product_total !== e.prod) report("product_total", out_product_total, e.prod);
        if (out_sigma_ij_total !== e.tij) report("sigma_ij_total", out_sigma_ij_total, e.tij);
        if (out_sigma_kl_total !== e.tkl) report("sigma_kl_total", out_sigma_kl_total, e.tkl);
        if (out_frames_done !== e.frames) report("frames_done", 64'(out_frames_done), 64'(e.frames));
      end
    end
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        for (int k = 0; k < 400; k++) @(posedge clk);
        hold_req = 0;
      end
      w = calm ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(input logic op, input logic [24:0] x, y, z, input bit typed);
    lj_word_t w;
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_diff_x <= x;
    in_diff_y <= y;
    in_diff_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lj_predict(op, x, y, z, w);
    if (typed) begin
      // pair with no effect right after reset: everything still zero
      w.hit = 0;
      w.born = 0; w.fij = 0; w.fkl = 0; w.prod = 0; w.tij = 0; w.tkl = 0; w.frames = 0;
    end
    lj_expected.push_back(w);
  endtask

  task automatic drain_idle();
    in_valid <= 0;
    @(posedge clk);
    while (lj_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1;
      cfg_index <= 3'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      case (cfg_reg_t'(i))
        REG_BOX:     box_q = 64'(v[i][23:0]);
        REG_CUT:     cut_q = 64'(v[i]);
        REG_P:       ax_p = v[i][1:0];
        REG_Q:       ax_q = v[i][1:0];
        REG_R:       ax_r = v[i][1:0];
        REG_S:       ax_s = v[i][1:0];
        REG_INV_VOL: inv_vol_q = 64'(v[i]);
        REG_RHO_T:   rho_t_q = 64'(v[i]);
        default: ;
      endcase
    end
    cfg_wr_en <= 0;
  endtask

  function automatic logic [24:0] rand_diff();
    int sel;
    logic [24:0] d;
    sel = $urandom_range(0, 19);
    if (sel < 14) d = 25'($urandom_range(0, 200000));
    else if (sel < 17) d = 25'(box_q[23:0] - $urandom_range(0, 100000));
    else d = 25'($urandom);
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  stim_row_t dir_rows[] = '{
    '{OP_PAIR,  25'd0, 25'd0, 25'd0, 1'b1},
    '{OP_PAIR,  25'h0400000, 25'h0400000, 25'h0400000, 1'b1},
    '{OP_FRAME, 25'd0, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  25'd65536, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  25'd80000, 25'd30000, -25'sd20000, 1'b0},
    '{OP_PAIR,  25'd327680, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  25'd327681, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  -25'sd327681, 25'd40000, 25'd0, 1'b0},
    '{OP_PAIR,  25'h0ffffff, 25'h1000000, 25'h0ffffff, 1'b0},
    '{OP_PAIR,  25'h1000000, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  -25'sd70000, -25'sd50000, 25'd60000, 1'b0},
    '{OP_FRAME, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff, 1'b0},
    '{OP_PAIR,  25'd0, 25'd0, 25'd1, 1'b0},
    '{OP_PAIR,  25'd1, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  -25'sd1, -25'sd1, 25'd1, 1'b0},
    '{OP_FRAME, 25'd0, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  25'd300, -25'sd200, 25'd100, 1'b0},
    '{OP_FRAME, 25'd0, 25'd0, 25'd0, 1'b0},
    '{OP_PAIR,  25'd100000, 25'd100000, 25'd100000, 1'b0},
    '{OP_FRAME, 25'd0, 25'd0, 25'd0, 1'b0}
  };

  initial begin
    logic [31:0] regs[8];
    box_q = 64'd655360; cut_q = 64'd409600; inv_vol_q = 64'd4294967; rho_t_q = 64'd4359392;
    ax_p = 1; ax_q = 1; ax_r = 1; ax_s = 1;
    born_q = 0; fij_q = 0; fkl_q = 0; prod_q = 0; tij_q = 0; tkl_q = 0; frames_q = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].dx, dir_rows[i].dy, dir_rows[i].dz, dir_rows[i].typed);

    for (int ph = 0; ph < 8; ph++) begin
      drain_idle();
      calm = (ph == 4);
      case (ph)
        0: regs = '{32'hffffff, 32'hffffffff, 32'd2, 32'd3, 32'd3, 32'd3,
                    32'hffffffff, 32'hffffffff};
        1: regs = '{32'd0, 32'd1638400, 32'd0, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0};
        2: regs = '{32'd655360, 32'd0, 32'd1, 32'd2, 32'd3, 32'd3, 32'd4294967, 32'd4359392};
        default: begin
          regs[0] = $urandom_range(200000, 1500000);
          regs[1] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(100000, 3000000);
          for (int k = 2; k < 6; k++) regs[k] = $urandom_range(0, 3);
          regs[6] = $urandom;
          regs[7] = $urandom;
        end
      endcase
      write_regs(regs);
      for (int n = 0; n < 105; n++) begin
        if (ph == 3 && n == 20) hold_req = 1;
        if (ph == 5 && n == 50) begin
          in_valid <= 0;
          @(posedge clk);
          while (lj_expected.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 11) == 0) send(OP_FRAME, 25'($urandom), 25'($urandom),
                                             25'($urandom), 1'b0);
        else send(OP_PAIR, rand_diff(), rand_diff(), rand_diff(), 1'b0);
      end
    end

    drain_idle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
